[rtl/ifr_pkg.sv]
// Shared types, widths and codes for the idle-timeout frame receiver.
package ifr_pkg;

    localparam int NUM_BUFFERS_DEF = 4;
    localparam int FRAME_BYTES_DEF = 64;

    localparam int IDLE_W   = 16;
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int RBUF_W   = 2;
    localparam int RIDX_W   = 6;
    localparam int DBUF_W   = 2;
    localparam int DLEN_W   = 7;
    localparam int FILL_W   = 6;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 16'd10;
    localparam logic [IDLE_W-1:0] IDLE_MAX         = 16'hFFFF;

    localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

    // Result of one item as it leaves the control stage; read data joins later.
    typedef struct packed {
        logic              frame_done;
        logic [DBUF_W-1:0] done_buffer;
        logic [DLEN_W-1:0] done_length;
        logic [FILL_W-1:0] fill_count;
        logic              read_valid;
    } ifr_result_t;

endpackage

[rtl/ifr_store.sv]
// Frame byte store: one write port and one read port with registered read data.
module ifr_store
    import ifr_pkg::*;
#(
    parameter int DEPTH = NUM_BUFFERS_DEF * FRAME_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [BYTE_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [BYTE_W-1:0]        rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ifr_ctrl.sv]
// Frame fill control: fill position, idle counter, buffer ring and store access.
module ifr_ctrl
    import ifr_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    localparam int DEPTH  = NUM_BUFFERS * FRAME_BYTES,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDLE_W-1:0]   cfg_wdata,
    input  logic                accept,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [RBUF_W-1:0]   read_buffer,
    input  logic [RIDX_W-1:0]   read_index,
    output logic                mem_wr_en,
    output logic [ADDR_W-1:0]   mem_wr_addr,
    output logic [BYTE_W-1:0]   mem_wr_data,
    output logic                mem_rd_en,
    output logic [ADDR_W-1:0]   mem_rd_addr,
    output ifr_result_t         result
);

    localparam int BUF_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam logic [BUF_W-1:0] LAST_BUF   = BUF_W'(NUM_BUFFERS - 1);
    localparam logic [LEN_W-1:0] FULL_LEN   = LEN_W'(FRAME_BYTES);
    localparam logic [ADDR_W-1:0] FRAME_STEP = ADDR_W'(FRAME_BYTES);

    logic [IDLE_W-1:0] timeout_reg;
    logic [POS_W-1:0]  fill_reg, fill_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [BUF_W-1:0]  filling_reg, filling_next;
    logic [BUF_W-1:0]  closed_buf_reg, closed_buf_next;
    logic [LEN_W-1:0]  closed_len_reg, closed_len_next;

    logic [LEN_W-1:0]  pos_inc;
    logic [IDLE_W-1:0] idle_inc;
    logic              close;
    logic [LEN_W-1:0]  close_len;
    logic              read_ok;

    assign pos_inc  = LEN_W'(fill_reg) + LEN_W'(1);
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + IDLE_W'(1);
    assign read_ok  = (int'(read_buffer) < NUM_BUFFERS) && (int'(read_index) < FRAME_BYTES);

    always_comb begin
        close     = 1'b0;
        close_len = pos_inc;
        fill_next = fill_reg;
        idle_next = idle_reg;
        case (action)
            ACT_BYTE: begin
                fill_next = POS_W'(pos_inc);
                idle_next = '0;
                close     = (pos_inc == FULL_LEN);
            end
            ACT_TICK: begin
                close_len = LEN_W'(fill_reg);
                if (fill_reg != '0) begin
                    idle_next = idle_inc;
                    close     = (idle_inc >= timeout_reg);
                end
            end
            default: begin
            end
        endcase

        filling_next    = filling_reg;
        closed_buf_next = closed_buf_reg;
        closed_len_next = closed_len_reg;
        if (close) begin
            closed_buf_next = filling_reg;
            closed_len_next = close_len;
            filling_next    = (filling_reg == LAST_BUF) ? '0 : filling_reg + BUF_W'(1);
            fill_next       = '0;
            idle_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= IDLE_TIMEOUT_RST;
            fill_reg       <= '0;
            idle_reg       <= '0;
            filling_reg    <= '0;
            closed_buf_reg <= '0;
            closed_len_reg <= '0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (accept) begin
                fill_reg       <= fill_next;
                idle_reg       <= idle_next;
                filling_reg    <= filling_next;
                closed_buf_reg <= closed_buf_next;
                closed_len_reg <= closed_len_next;
            end
        end
    end

    assign mem_wr_en   = accept && (action == ACT_BYTE);
    assign mem_wr_addr = ADDR_W'(filling_reg) * FRAME_STEP + ADDR_W'(fill_reg);
    assign mem_wr_data = rx_byte;

    assign mem_rd_en   = accept && (action == ACT_READ) && read_ok;
    assign mem_rd_addr = ADDR_W'(read_buffer) * FRAME_STEP + ADDR_W'(read_index);

    assign result.frame_done  = close;
    assign result.done_buffer = DBUF_W'(closed_buf_next);
    assign result.done_length = DLEN_W'(closed_len_next);
    assign result.fill_count  = FILL_W'(fill_next);
    assign result.read_valid  = (action == ACT_READ) && read_ok;

endmodule

[rtl/ifr_out.sv]
// Result pipeline: stage s1 waits for store read data, then holds the output item.
module ifr_out
    import ifr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  ifr_result_t          result,
    input  logic [BYTE_W-1:0]    rd_data,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic                 s1_valid_reg, s1_valid_next;
    ifr_result_t          s1_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;
    logic                 s1_adv;
    logic [BYTE_W-1:0]    read_data;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign ready     = !s1_valid_reg || !out_valid_reg || m_tready;
    assign read_data = s1_reg.read_valid ? rd_data : '0;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= result;
        end
        if (s1_adv) begin
            out_last_reg <= s1_reg.frame_done;
            out_data_reg <= {1'b0, s1_reg.fill_count, read_data,
                             s1_reg.done_length, s1_reg.done_buffer};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/idle_timeout_frame_receiver_core.sv]
// An accepted item is registered in stage s1 and then in the output register, where
// it drives its result; while m_tready is low it can wait in either stage.
// Throughput: one item per cycle if m_tready allows; at most one store write or read per item.
// Read data comes from the frame store in the cycle after the address is issued.
// Reset (aresetn low, synchronous) empties the pipeline, sets idle_timeout to 10
// and clears fill, idle and buffer state; store contents stay as they were.
module idle_timeout_frame_receiver_core
    import ifr_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [IDLE_W-1:0]    cfg_wdata,    // idle_timeout
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // rx_byte, read_buffer, read_index
    input  logic [ACTION_W-1:0]  s_tuser,      // action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // done_buffer, done_length, read_data, fill_count
    output logic                 m_tlast       // frame_done
);

    localparam int DEPTH  = NUM_BUFFERS * FRAME_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              accept;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [BYTE_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data;
    ifr_result_t       result;

    assign accept = s_tvalid && s_tready;

    ifr_ctrl #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .action      (s_tuser),
        .rx_byte     (s_tdata[7:0]),
        .read_buffer (s_tdata[9:8]),
        .read_index  (s_tdata[15:10]),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .result      (result)
    );

    ifr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ifr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .result   (result),
        .rd_data  (mem_rd_data),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/ifr_checker.sv]
// Port-level checks for the idle-timeout frame receiver, bound to its top level.
module ifr_checker
    import ifr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With the pipeline empty after reset, the input side is open.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A closed frame always leaves the next buffer empty.
    a_close_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[22:17] == 6'd0)
        else $error("frame closed with bytes left in the fill buffer");

endmodule

bind idle_timeout_frame_receiver_core ifr_checker u_ifr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
